// File: hdl/lrfb_pkg.sv
// Package for the line raster framebuffer engine.
// Holds the shared types, action and mode codes and geometry defaults.
// No dependencies.
package lrfb_pkg;

    localparam int WIDTH_DEF  = 84;
    localparam int HEIGHT_DEF = 48;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        ACT_LINE  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_RANGE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_ON   = 2'd1,
        MODE_XOR  = 2'd2,
        MODE_KEEP = 2'd3
    } mode_t;

    // One classified command passed from the front end to the back end.
    typedef struct packed {
        action_t     act;
        logic [7:0]  x0;
        logic [7:0]  y0;
        logic [7:0]  x1;
        logic [7:0]  y1;
        logic [8:0]  ax;      // |x1-x0|
        logic [8:0]  ay;      // |y1-y0|
        logic        sx_neg;
        logic        sy_neg;
        mode_t       mode;
        logic [8:0]  ridx;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_PLOT,
        ST_RD_WAIT,
        ST_WRITE,
        ST_STEP,
        ST_READ_WAIT,
        ST_READ_DONE,
        ST_CLEAR,
        ST_RANGE_DIV,
        ST_RESULT
    } be_state_t;

endpackage

// File: hdl/line_raster_framebuffer_engine.sv
// Top level of the line raster framebuffer engine.
// Uses lrfb_pkg, lrfb_front, lrfb_back (which holds lrfb_ram).
//
//  channel | signals                                   | role
//  in      | in_valid/in_ready, action..read_index     | commands
//  out     | out_valid/out_ready, read_byte..bank_cmd  | one result per command
//
// A line walks each on-screen pixel through plot, read wait, write and step,
// an off-screen pixel through plot and step only, for the byte read-modify-write
// through the single framebuffer port. A read goes through read wait and read done.
// Clear sweeps the store, one byte a cycle.
// Take-range divides by repeated subtraction.
// After reset the back end first zeroes the store.
// A two-entry queue lets input be taken while the back end works or stalls;
// a waiting result holds the back end before its next command.
module line_raster_framebuffer_engine
    import lrfb_pkg::*;
#(
    parameter int WIDTH  = WIDTH_DEF,
    parameter int HEIGHT = HEIGHT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] action,
    input  logic [7:0] start_x,
    input  logic [7:0] start_y,
    input  logic [7:0] end_x,
    input  logic [7:0] end_y,
    input  logic [1:0] draw_mode,
    input  logic [8:0] read_index,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_byte,
    output logic [8:0] range_low,
    output logic [8:0] range_high,
    output logic       range_nonempty,
    output logic [7:0] column_command,
    output logic [6:0] bank_command
);
    cmd_t cmd;
    logic cmd_valid, cmd_ready;

    lrfb_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .clk(clk), .rst_n(rst_n), .valid(in_valid), .ready(in_ready),
        .action(action), .start_x(start_x), .start_y(start_y),
        .end_x(end_x), .end_y(end_y), .draw_mode(draw_mode),
        .read_index(read_index), .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready), .cmd(cmd)
    );

    lrfb_back #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
        .cmd(cmd), .out_valid(out_valid), .out_ready(out_ready),
        .read_byte(read_byte), .range_low(range_low), .range_high(range_high),
        .range_nonempty(range_nonempty), .column_command(column_command),
        .bank_command(bank_command)
    );
endmodule

// File: hdl/lrfb_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module lrfb_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 504
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [DATA_W-1:0]        wdata,
    output logic [DATA_W-1:0]        rdata
);
    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

// File: hdl/lrfb_front.sv
// Front end: accepts input transactions, classifies them and queues them.
// Uses lrfb_pkg.
module lrfb_front
    import lrfb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       valid,
    output logic       ready,
    input  logic [1:0] action,
    input  logic [7:0] start_x,
    input  logic [7:0] start_y,
    input  logic [7:0] end_x,
    input  logic [7:0] end_y,
    input  logic [1:0] draw_mode,
    input  logic [8:0] read_index,
    output logic       cmd_valid,
    input  logic       cmd_ready,
    output cmd_t       cmd
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cmd_t          q_reg [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    cmd_t          c;
    logic          push, pop;

    // Classify: absolute deltas and step directions
    always_comb
    begin
        c.act    = action_t'(action);
        c.x0     = start_x;
        c.y0     = start_y;
        c.x1     = end_x;
        c.y1     = end_y;
        c.sx_neg = end_x < start_x;
        c.sy_neg = end_y < start_y;
        c.ax     = c.sx_neg ? {1'b0, start_x - end_x} : {1'b0, end_x - start_x};
        c.ay     = c.sy_neg ? {1'b0, start_y - end_y} : {1'b0, end_y - start_y};
        c.mode   = mode_t'(draw_mode);
        c.ridx   = read_index;
    end

    assign ready     = cnt_reg != (AW+1)'(DEPTH);
    assign cmd_valid = cnt_reg != '0;
    assign cmd       = q_reg[rp_reg];
    assign push      = valid && ready;
    assign pop       = cmd_valid && cmd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= c;
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (pop)
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

// File: hdl/lrfb_back.sv
// Back end: Bresenham walker, byte read-modify-write, clear sweep, dirty range.
// Uses lrfb_pkg and lrfb_ram.
module lrfb_back
    import lrfb_pkg::*;
#(
    parameter int WIDTH  = WIDTH_DEF,
    parameter int HEIGHT = HEIGHT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  cmd_t       cmd,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_byte,
    output logic [8:0] range_low,
    output logic [8:0] range_high,
    output logic       range_nonempty,
    output logic [7:0] column_command,
    output logic [6:0] bank_command
);
    localparam int BANKS = HEIGHT / 8;
    localparam int SIZE  = WIDTH * BANKS;
    localparam int YMAX  = BANKS * 8;
    localparam int AW    = $clog2(SIZE);

    be_state_t   st_reg, st_next;
    cmd_t        c_reg;
    logic [7:0]  x_reg, y_reg;
    logic signed [10:0] err_reg;
    logic [8:0]  lo_reg, hi_reg;
    logic [AW-1:0] addr_reg;
    logic [AW-1:0] clr_reg;
    logic [2:0]  bit_reg;
    logic [8:0]  div_rem_reg;
    logic [5:0]  div_q_reg;
    logic [7:0]  ob_reg;
    logic [8:0]  ol_reg, oh_reg;
    logic        one_reg;
    logic [7:0]  oc_reg;
    logic [6:0]  ok_reg;
    logic        ov_reg;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wd, ram_rd;
    logic          xmajor, done;
    logic          on_pix;
    logic [8:0]    idx_calc;
    logic [8:0]    clo, chi;
    logic          out_free;

    lrfb_ram #(.DATA_W(8), .DEPTH(SIZE)) u_ram (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd)
    );

    assign xmajor   = c_reg.ax > c_reg.ay;
    assign done     = xmajor ? (x_reg == c_reg.x1) : (y_reg == c_reg.y1);
    assign on_pix   = (x_reg < 8'(WIDTH)) && (9'(y_reg) < 9'(YMAX));
    assign idx_calc = 9'(({4'd0, y_reg[7:3]} * 9'(WIDTH)) + {1'b0, x_reg});
    assign clo      = (lo_reg >= 9'(SIZE)) ? 9'(SIZE-1) : lo_reg;
    assign chi      = (hi_reg >= 9'(SIZE)) ? 9'(SIZE-1) : hi_reg;
    assign out_free = !ov_reg || out_ready;

    // Next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_INIT:      st_next = (clr_reg == AW'(SIZE-1)) ? ST_IDLE : ST_INIT;
            ST_IDLE:
                if (cmd_valid && !ov_reg)
                begin
                    unique case (cmd.act)
                        ACT_LINE:  st_next = ST_PLOT;
                        ACT_READ:  st_next = ST_READ_WAIT;
                        ACT_CLEAR: st_next = ST_CLEAR;
                        ACT_RANGE: st_next = ST_RANGE_DIV;
                    endcase
                end
            ST_PLOT:      st_next = on_pix ? ST_RD_WAIT : ST_STEP;
            ST_RD_WAIT:   st_next = ST_WRITE;
            ST_WRITE:     st_next = ST_STEP;
            ST_STEP:      st_next = done ? ST_RESULT : ST_PLOT;
            ST_READ_WAIT: st_next = ST_READ_DONE;
            ST_READ_DONE: st_next = ST_RESULT;
            ST_CLEAR:     st_next = (clr_reg == AW'(SIZE-1)) ? ST_RESULT : ST_CLEAR;
            ST_RANGE_DIV: st_next = (div_rem_reg < 9'(WIDTH)) ? ST_RESULT : ST_RANGE_DIV;
            ST_RESULT:    st_next = out_free ? ST_IDLE : ST_RESULT;
            default:      st_next = ST_IDLE;
        endcase
    end

    // Outputs of the state machine
    always_comb
    begin
        cmd_ready = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = addr_reg;
        ram_wd    = ram_rd;
        unique case (st_reg)
            ST_IDLE:
            begin
                // a waiting result holds off the next command
                cmd_ready = !ov_reg;
                ram_addr  = AW'(cmd.ridx);
            end
            ST_READ_WAIT:
                ram_addr = AW'(c_reg.ridx);
            ST_WRITE:
            begin
                ram_we = 1'b1;
                unique case (c_reg.mode)
                    MODE_OFF:  ram_wd = ram_rd & ~(8'd1 << bit_reg);
                    MODE_ON:   ram_wd = ram_rd | (8'd1 << bit_reg);
                    MODE_XOR:  ram_wd = ram_rd ^ (8'd1 << bit_reg);
                    MODE_KEEP: ram_wd = ram_rd;
                endcase
            end
            ST_INIT, ST_CLEAR:
            begin
                ram_we   = 1'b1;
                ram_addr = clr_reg;
                ram_wd   = 8'd0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_INIT;
            lo_reg <= 9'(SIZE-1);
            hi_reg <= '0;
            ov_reg <= 1'b0;
            clr_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (ov_reg && out_ready)
                ov_reg <= 1'b0;
            unique case (st_reg)
                // zeroing sweep after reset, dirty range untouched
                ST_INIT:
                    clr_reg <= clr_reg + 1'b1;
                ST_IDLE:
                    clr_reg <= '0;
                ST_WRITE:
                begin
                    if (idx_calc < lo_reg) lo_reg <= idx_calc;
                    if (idx_calc > hi_reg) hi_reg <= idx_calc;
                end
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(SIZE-1))
                    begin
                        lo_reg <= '0;
                        hi_reg <= 9'(SIZE-1);
                    end
                end
                ST_RANGE_DIV:
                    if (div_rem_reg < 9'(WIDTH))
                    begin
                        lo_reg <= 9'(SIZE-1);
                        hi_reg <= '0;
                    end
                ST_RESULT:
                    if (out_free)
                        ov_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            ST_IDLE:
            begin
                c_reg   <= cmd;
                x_reg   <= cmd.x0;
                y_reg   <= cmd.y0;
                err_reg <= (cmd.ax > cmd.ay)
                    ? $signed({1'b0, cmd.ay, 1'b0}) - $signed({2'b0, cmd.ax})
                    : $signed({1'b0, cmd.ax, 1'b0}) - $signed({2'b0, cmd.ay});
                // result fields stay put while a result waits
                if (!ov_reg)
                begin
                    ob_reg  <= '0;
                    ol_reg  <= '0;
                    oh_reg  <= '0;
                    one_reg <= 1'b0;
                    oc_reg  <= '0;
                    ok_reg  <= '0;
                end
                div_rem_reg <= (lo_reg >= 9'(SIZE)) ? 9'(SIZE-1) : lo_reg;
                div_q_reg   <= '0;
            end
            ST_PLOT:
            begin
                addr_reg <= AW'(idx_calc);
                bit_reg  <= y_reg[2:0];
            end
            ST_STEP:
                if (!done)
                begin
                    if (xmajor)
                    begin
                        if (!err_reg[10])
                        begin
                            y_reg   <= c_reg.sy_neg ? y_reg - 1'b1 : y_reg + 1'b1;
                            err_reg <= err_reg - $signed({1'b0, c_reg.ax, 1'b0})
                                       + $signed({1'b0, c_reg.ay, 1'b0});
                        end
                        else
                            err_reg <= err_reg + $signed({1'b0, c_reg.ay, 1'b0});
                        x_reg <= c_reg.sx_neg ? x_reg - 1'b1 : x_reg + 1'b1;
                    end
                    else
                    begin
                        if (!err_reg[10])
                        begin
                            x_reg   <= c_reg.sx_neg ? x_reg - 1'b1 : x_reg + 1'b1;
                            err_reg <= err_reg - $signed({1'b0, c_reg.ay, 1'b0})
                                       + $signed({1'b0, c_reg.ax, 1'b0});
                        end
                        else
                            err_reg <= err_reg + $signed({1'b0, c_reg.ax, 1'b0});
                        y_reg <= c_reg.sy_neg ? y_reg - 1'b1 : y_reg + 1'b1;
                    end
                end
            ST_READ_DONE:
                ob_reg <= (c_reg.ridx < 9'(SIZE)) ? ram_rd : 8'd0;
            ST_RANGE_DIV:
                // Repeated subtraction: at most BANKS steps
                if (div_rem_reg >= 9'(WIDTH))
                begin
                    div_rem_reg <= div_rem_reg - 9'(WIDTH);
                    div_q_reg   <= div_q_reg + 1'b1;
                end
                else
                begin
                    ol_reg  <= clo;
                    oh_reg  <= chi;
                    one_reg <= clo <= chi;
                    oc_reg  <= 8'h80 | div_rem_reg[7:0];
                    ok_reg  <= 7'h40 | {1'b0, div_q_reg};
                end
            default: ;
        endcase
    end

    assign out_valid      = ov_reg;
    assign read_byte      = ob_reg;
    assign range_low      = ol_reg;
    assign range_high     = oh_reg;
    assign range_nonempty = one_reg;
    assign column_command = oc_reg;
    assign bank_command   = ok_reg;
endmodule

// File: sim/line_raster_framebuffer_engine_tb.sv
// Self-checking testbench for line_raster_framebuffer_engine.
// Uses lrfb_pkg; drives directed then random commands through valid/ready and
// checks each result against a local framebuffer and dirty-range predictor.
`timescale 1ns / 100ps

module line_raster_framebuffer_engine_tb;
    import lrfb_pkg::*;

    localparam int FB_W     = WIDTH_DEF;
    localparam int FB_H     = HEIGHT_DEF;
    localparam int FB_ROWS  = (FB_H / 8) * 8;
    localparam int FB_SIZE  = FB_W * (FB_H / 8);
    localparam int N_RANDOM = 1150;
    localparam int WD_LIMIT = 20000;
    localparam int HOLD_LEN = 400;

    typedef struct packed {
        logic [7:0] rbyte;
        logic [8:0] lo;
        logic [8:0] hi;
        logic       nonempty;
        logic [7:0] col;
        logic [6:0] bank;
    } result_t;

    typedef struct {
        action_t    act;
        logic [7:0] x0;
        logic [7:0] y0;
        logic [7:0] x1;
        logic [7:0] y1;
        mode_t      mode;
        logic [8:0] ridx;
        bit         typed;
        result_t    want;
    } job_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] action;
    logic [7:0] start_x;
    logic [7:0] start_y;
    logic [7:0] end_x;
    logic [7:0] end_y;
    logic [1:0] draw_mode;
    logic [8:0] read_index;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] read_byte;
    logic [8:0] range_low;
    logic [8:0] range_high;
    logic       range_nonempty;
    logic [7:0] column_command;
    logic [6:0] bank_command;

    // predictor state
    logic [7:0] pix_bytes [FB_SIZE];
    int         dirty_lo;
    int         dirty_hi;

    result_t    pending_results[$];
    job_t       directed[$];
    int         errors;
    int         idle_cycles;
    bit         calm;
    bit         hold_now;
    bit         hold_done;
    int         hold_cnt;

    line_raster_framebuffer_engine i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .start_x        (start_x),
        .start_y        (start_y),
        .end_x          (end_x),
        .end_y          (end_y),
        .draw_mode      (draw_mode),
        .read_index     (read_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_byte      (read_byte),
        .range_low      (range_low),
        .range_high     (range_high),
        .range_nonempty (range_nonempty),
        .column_command (column_command),
        .bank_command   (bank_command)
    );

    always #10 clk = ~clk;

    // one pixel read-modify-write; off-screen pixels are skipped
    function automatic void put_pixel(int x, int y, mode_t m);
        int         idx;
        logic [7:0] b;
        if (x < 0 || y < 0 || x >= FB_W || y >= FB_ROWS)
            return;
        idx = (y / 8) * FB_W + x;
        b = 8'(1 << (y % 8));
        case (m)
            MODE_OFF: pix_bytes[idx] &= ~b;
            MODE_ON:  pix_bytes[idx] |= b;
            MODE_XOR: pix_bytes[idx] ^= b;
            default:  ;
        endcase
        if (idx < dirty_lo) dirty_lo = idx;
        if (idx > dirty_hi) dirty_hi = idx;
    endfunction

    // Bresenham walk, major axis chosen by doubled deltas
    function automatic void walk_line(int x0, int y0, int x1, int y1, mode_t m);
        int dx, dy, sx, sy, err;
        dx = x1 - x0;
        dy = y1 - y0;
        sx = 1;
        sy = 1;
        if (dx < 0) begin dx = -dx; sx = -1; end
        if (dy < 0) begin dy = -dy; sy = -1; end
        dx *= 2;
        dy *= 2;
        put_pixel(x0, y0, m);
        if (dx > dy)
        begin
            err = dy - dx / 2;
            while (x0 != x1)
            begin
                if (err >= 0) begin y0 += sy; err -= dx; end
                x0 += sx;
                err += dy;
                put_pixel(x0, y0, m);
            end
        end
        else
        begin
            err = dx - dy / 2;
            while (y0 != y1)
            begin
                if (err >= 0) begin x0 += sx; err -= dy; end
                y0 += sy;
                err += dx;
                put_pixel(x0, y0, m);
            end
        end
    endfunction

    function automatic result_t apply_command(job_t j);
        result_t r;
        int      lo, hi;
        r = '0;
        case (j.act)
            ACT_LINE: walk_line(j.x0, j.y0, j.x1, j.y1, j.mode);
            ACT_READ: if (j.ridx < FB_SIZE) r.rbyte = pix_bytes[j.ridx];
            ACT_CLEAR:
            begin
                foreach (pix_bytes[i]) pix_bytes[i] = '0;
                dirty_lo = 0;
                dirty_hi = FB_SIZE - 1;
            end
            default:
            begin
                lo = (dirty_lo >= FB_SIZE) ? FB_SIZE - 1 : dirty_lo;
                hi = (dirty_hi >= FB_SIZE) ? FB_SIZE - 1 : dirty_hi;
                r.lo = 9'(lo);
                r.hi = 9'(hi);
                r.nonempty = (lo <= hi);
                r.col = 8'(8'h80 | (lo % FB_W));
                r.bank = 7'(7'h40 | (lo / FB_W));
                dirty_lo = FB_SIZE - 1;
                dirty_hi = 0;
            end
        endcase
        return r;
    endfunction

    function automatic job_t mk(action_t a, int x0, int y0, int x1, int y1, mode_t m,
                                int ri);
        job_t j;
        j.act = a;
        j.x0 = 8'(x0);
        j.y0 = 8'(y0);
        j.x1 = 8'(x1);
        j.y1 = 8'(y1);
        j.mode = m;
        j.ridx = 9'(ri);
        j.typed = 0;
        j.want = '0;
        return j;
    endfunction

    function automatic job_t with_want(job_t j, result_t w);
        j.typed = 1;
        j.want = w;
        return j;
    endfunction

    function automatic job_t random_job();
        job_t j;
        int   pick;
        pick = $urandom_range(0, 99);
        j = mk(ACT_RANGE, $urandom_range(0, 255), $urandom_range(0, 255),
               $urandom_range(0, 255), $urandom_range(0, 255),
               mode_t'($urandom_range(0, 3)), $urandom_range(0, 511));
        if (pick < 52)
        begin
            j.act = ACT_LINE;
            // mostly short lines near the panel, some across the full field
            if ($urandom_range(0, 9) < 7)
            begin
                j.x0 = 8'($urandom_range(0, 99));
                j.x1 = 8'($urandom_range(0, 99));
                j.y0 = 8'($urandom_range(0, 59));
                j.y1 = 8'($urandom_range(0, 59));
            end
        end
        else if (pick < 80)
        begin
            j.act = ACT_READ;
            if ($urandom_range(0, 9) != 0) j.ridx = 9'($urandom_range(0, FB_SIZE - 1));
        end
        else if (pick < 83)
            j.act = ACT_CLEAR;
        return j;
    endfunction

    // drive one transaction and record its expected result on acceptance
    task automatic offer(job_t j);
        result_t r;
        in_valid   <= 1'b1;
        action     <= j.act;
        start_x    <= j.x0;
        start_y    <= j.y0;
        end_x      <= j.x1;
        end_y      <= j.y1;
        draw_mode  <= j.mode;
        read_index <= j.ridx;
        do @(posedge clk); while (!in_ready);
        r = apply_command(j);
        if (j.typed) r = j.want;
        pending_results.push_back(r);
        if (!calm && $urandom_range(0, 99) < 38)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // receiver: random stalls, one long hold-off, result checking
    always @(posedge clk)
    begin
        result_t e;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result with none expected", $time);
                    errors++;
                end
                else
                begin
                    e = pending_results.pop_front();
                    check_field("read_byte", e.rbyte, read_byte);
                    check_field("range_low", e.lo, range_low);
                    check_field("range_high", e.hi, range_high);
                    check_field("range_nonempty", e.nonempty, range_nonempty);
                    check_field("column_command", e.col, column_command);
                    check_field("bank_command", e.bank, bank_command);
                end
            end
            if (hold_now && !hold_done)
            begin
                out_ready <= 1'b0;
                hold_cnt++;
                if (hold_cnt >= HOLD_LEN) hold_done = 1;
            end
            else
                out_ready <= calm || ($urandom_range(0, 99) >= 38);
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("line_raster_framebuffer_engine_tb: errors");
            $finish;
        end
    end

    initial
    begin
        result_t empty_rng;
        result_t full_rng;
        result_t rb;
        clk = 0;
        rst_n = 0;
        in_valid = 0;
        action = '0;
        start_x = '0;
        start_y = '0;
        end_x = '0;
        end_y = '0;
        draw_mode = '0;
        read_index = '0;
        out_ready = 0;
        errors = 0;
        idle_cycles = 0;
        calm = 0;
        hold_now = 0;
        hold_done = 0;
        hold_cnt = 0;
        foreach (pix_bytes[i]) pix_bytes[i] = '0;
        dirty_lo = FB_SIZE - 1;
        dirty_hi = 0;

        empty_rng = '{rbyte: 8'd0, lo: 9'd503, hi: 9'd0, nonempty: 1'b0,
                      col: 8'd211, bank: 7'd69};
        full_rng  = '{rbyte: 8'd0, lo: 9'd0, hi: 9'd503, nonempty: 1'b1,
                      col: 8'h80, bank: 7'h40};
        rb = '0;

        // directed table: extremes, every action and mode, special cases
        directed.push_back(with_want(mk(ACT_READ, 0, 0, 0, 0, MODE_OFF, 0), rb));
        directed.push_back(with_want(mk(ACT_RANGE, 0, 0, 0, 0, MODE_OFF, 0), empty_rng));
        directed.push_back(mk(ACT_LINE, 0, 0, 0, 0, MODE_ON, 0));
        rb.rbyte = 8'h01;
        directed.push_back(with_want(mk(ACT_READ, 0, 0, 0, 0, MODE_OFF, 0), rb));
        directed.push_back(mk(ACT_LINE, 83, 47, 83, 47, MODE_ON, 0));
        rb.rbyte = 8'h80;
        directed.push_back(with_want(mk(ACT_READ, 0, 0, 0, 0, MODE_OFF, 503), rb));
        rb.rbyte = 8'h00;
        directed.push_back(with_want(mk(ACT_READ, 0, 0, 0, 0, MODE_OFF, 504), rb));
        directed.push_back(with_want(mk(ACT_READ, 0, 0, 0, 0, MODE_OFF, 511), rb));
        directed.push_back(mk(ACT_RANGE, 0, 0, 0, 0, MODE_OFF, 0));
        directed.push_back(mk(ACT_LINE, 84, 0, 255, 255, MODE_ON, 0));
        directed.push_back(with_want(mk(ACT_RANGE, 0, 0, 0, 0, MODE_OFF, 0), empty_rng));
        directed.push_back(mk(ACT_LINE, 255, 255, 0, 0, MODE_XOR, 0));
        directed.push_back(mk(ACT_LINE, 0, 47, 83, 0, MODE_KEEP, 0));
        directed.push_back(mk(ACT_LINE, 10, 5, 60, 40, MODE_OFF, 0));
        directed.push_back(mk(ACT_READ, 0, 0, 0, 0, MODE_OFF, 130));
        directed.push_back(mk(ACT_RANGE, 0, 0, 0, 0, MODE_OFF, 0));
        directed.push_back(with_want(mk(ACT_CLEAR, 0, 0, 0, 0, MODE_OFF, 0), '0));
        directed.push_back(with_want(mk(ACT_RANGE, 0, 0, 0, 0, MODE_OFF, 0), full_rng));
        directed.push_back(mk(ACT_LINE, 5, 0, 7, 40, MODE_ON, 0));
        directed.push_back(mk(ACT_READ, 0, 0, 0, 0, MODE_OFF, 173));
        directed.push_back(mk(ACT_LINE, 200, 3, 0, 3, MODE_ON, 0));
        directed.push_back(mk(ACT_LINE, 40, 48, 40, 0, MODE_XOR, 0));
        directed.push_back(mk(ACT_RANGE, 0, 0, 0, 0, MODE_OFF, 0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i]) offer(directed[i]);

        // random commands with a calm stretch and one long receiver hold-off
        for (int n = 0; n < N_RANDOM; n++)
        begin
            calm = (n >= 500 && n < 700);
            if (n == 600) hold_now = 1;
            offer(random_job());
        end
        in_valid <= 1'b0;
        calm = 0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (pending_results.size() == 0 && errors == 0)
            $display("line_raster_framebuffer_engine_tb: clean");
        else
            $display("line_raster_framebuffer_engine_tb: errors");
        $finish;
    end

endmodule

// File: files.f
hdl/lrfb_pkg.sv
hdl/lrfb_ram.sv
hdl/lrfb_front.sv
hdl/lrfb_back.sv
hdl/line_raster_framebuffer_engine.sv
sim/line_raster_framebuffer_engine_tb.sv
